// ----- hdl/ats_pkg.sv -----
// Package for the axisymmetric triangle stiffness kernel.
// Holds widths, register indexes and the result type; depends on nothing.
`default_nettype none

package ats_pkg;

   // Coordinate and difference widths (Q12.12 coordinates)
   localparam int CW   = 24;
   localparam int DW   = 25;
   localparam int SW   = 26;
   localparam int SUW  = 25;
   // Product, dot product and magnitude widths (Q24.24)
   localparam int PW   = 50;
   localparam int DOTW = 51;
   localparam int MAGW = 50;
   localparam int HALFW = 25;
   localparam int M3W  = 52;
   // Denominator, numerator and divider widths
   localparam int DENW = 75;
   localparam int D2W  = 76;
   localparam int NW   = 80;
   localparam int QW   = 31;
   localparam int CMPW = D2W + QW;
   localparam int NUM_SHIFT = 28;
   localparam int DIVN = QW;

   // Result entries in order aa, ab, ac, bb, bc, cc
   localparam int NENT = 6;
   localparam int ENTW = 32;
   localparam int unsigned PAIR_I [NENT] = '{0, 0, 0, 1, 1, 2};
   localparam int unsigned PAIR_J [NENT] = '{0, 1, 2, 1, 2, 2};

   localparam logic [ENTW-1:0] ENT_MAX = 32'h7FFF_FFFF;
   localparam logic [ENTW-1:0] ENT_MIN = 32'h8000_0000;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int DET_THR_W  = 32;
   localparam int RAD_THR_W  = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_DET_THR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAD_THR = 1'b1;
   localparam logic [DET_THR_W-1:0] DET_THR_RST = 32'd1;
   localparam logic [RAD_THR_W-1:0] RAD_THR_RST = 23'd1;

   typedef struct packed {
      logic [NENT-1:0][ENTW-1:0] ent;
      logic                      deg;
   } res_type;

endpackage

`default_nettype wire

// ----- hdl/axisym_tri_stiffness.sv -----
// Top level of the axisymmetric linear triangle stiffness kernel.
// Depends on ats_pkg for widths, register indexes and the result type.
// Accepts one triangle per clock cycle unless stalled. The path is 41 register stages, the
// first loaded at the accepting edge: seven stages of differencing, multiplication and
// thresholding, an overflow check, the six 31-stage restoring divider lanes (one quotient bit
// per stage), the sign stage and the output register. The output register is backed by a skid
// register, so the input side keeps accepting while one result waits; the input stalls only
// once both hold a result. Configuration writes take effect at once.
`default_nettype none

module axisym_tri_stiffness import ats_pkg::*; (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   csr_wr_en,
   input  wire  logic [CSR_IDX_W-1:0]   csr_index,
   input  wire  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire  logic                   req_valid,
   output logic                         req_ready,
   input  wire  logic signed [CW-1:0]   req_axial_a,
   input  wire  logic signed [CW-1:0]   req_radial_a,
   input  wire  logic signed [CW-1:0]   req_axial_b,
   input  wire  logic signed [CW-1:0]   req_radial_b,
   input  wire  logic signed [CW-1:0]   req_axial_c,
   input  wire  logic signed [CW-1:0]   req_radial_c,
   output logic                         rsp_valid,
   input  wire  logic                   rsp_ready,
   output logic signed [ENTW-1:0]       rsp_entry_aa,
   output logic signed [ENTW-1:0]       rsp_entry_ab,
   output logic signed [ENTW-1:0]       rsp_entry_ac,
   output logic signed [ENTW-1:0]       rsp_entry_bb,
   output logic signed [ENTW-1:0]       rsp_entry_bc,
   output logic signed [ENTW-1:0]       rsp_entry_cc,
   output logic                         rsp_degenerate
);

   localparam int NST = 7 + DIVN + 2;

   // Configuration registers
   logic [DET_THR_W-1:0] det_thr_ff;
   logic [RAD_THR_W-1:0] rad_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_thr_ff <= DET_THR_RST;
         rad_thr_ff <= RAD_THR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DET_THR: det_thr_ff <= csr_wdata[DET_THR_W-1:0];
            CSR_RAD_THR: rad_thr_ff <= csr_wdata[RAD_THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: advance everything unless the skid register is occupied
   logic           ce;
   logic           accept;
   logic           push;
   logic [NST-1:0] vld_ff;
   logic           skid_v_ff;
   logic           out_v_ff;

   assign ce        = !skid_v_ff;
   assign req_ready = ce;
   assign accept    = req_valid && ce;
   assign push      = ce && vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[NST-2:0], accept};
      end
   end

   // Stage 1: coordinate differences and radial sum
   logic signed [DW-1:0] s1_dzba_ff, s1_drca_ff, s1_dzca_ff, s1_drba_ff;
   logic signed [DW-1:0] s1_gx_ff [3];
   logic signed [DW-1:0] s1_gy_ff [3];
   logic signed [SW-1:0] s1_sum_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_dzba_ff <= DW'(req_axial_b) - DW'(req_axial_a);
         s1_drca_ff <= DW'(req_radial_c) - DW'(req_radial_a);
         s1_dzca_ff <= DW'(req_axial_c) - DW'(req_axial_a);
         s1_drba_ff <= DW'(req_radial_b) - DW'(req_radial_a);
         s1_gx_ff[0] <= DW'(req_radial_b) - DW'(req_radial_c);
         s1_gy_ff[0] <= DW'(req_axial_c) - DW'(req_axial_b);
         s1_gx_ff[1] <= DW'(req_radial_c) - DW'(req_radial_a);
         s1_gy_ff[1] <= DW'(req_axial_a) - DW'(req_axial_c);
         s1_gx_ff[2] <= DW'(req_radial_a) - DW'(req_radial_b);
         s1_gy_ff[2] <= DW'(req_axial_b) - DW'(req_axial_a);
         s1_sum_ff <= SW'(req_radial_a) + SW'(req_radial_b) + SW'(req_radial_c);
      end
   end

   // Stage 2: all products, near-axis test
   logic [SUW-1:0]       thr3;
   logic signed [PW-1:0] s2_pd1_ff, s2_pd2_ff;
   logic signed [PW-1:0] s2_px_ff [NENT];
   logic signed [PW-1:0] s2_py_ff [NENT];
   logic [SUW-1:0]       s2_sum_ff;
   logic                 s2_near_ff;

   assign thr3 = SUW'({rad_thr_ff, 1'b0}) + SUW'(rad_thr_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_pd1_ff  <= PW'(s1_dzba_ff) * PW'(s1_drca_ff);
         s2_pd2_ff  <= PW'(s1_dzca_ff) * PW'(s1_drba_ff);
         s2_sum_ff  <= s1_sum_ff[SUW-1:0];
         s2_near_ff <= (s1_sum_ff <= $signed({1'b0, thr3}));
      end
   end

   for (genvar p = 0; p < NENT; p++) begin : g_prod
      always_ff @(posedge clock) begin
         if (ce) begin
            s2_px_ff[p] <= PW'(s1_gx_ff[PAIR_I[p]]) * PW'(s1_gx_ff[PAIR_J[p]]);
            s2_py_ff[p] <= PW'(s1_gy_ff[PAIR_I[p]]) * PW'(s1_gy_ff[PAIR_J[p]]);
         end
      end
   end

   // Stage 3: determinant and dot products
   logic signed [DOTW-1:0] s3_det_ff;
   logic signed [DOTW-1:0] s3_dot_ff [NENT];
   logic [SUW-1:0]         s3_sum_ff;
   logic                   s3_near_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_det_ff  <= DOTW'(s2_pd1_ff) - DOTW'(s2_pd2_ff);
         s3_sum_ff  <= s2_sum_ff;
         s3_near_ff <= s2_near_ff;
      end
   end

   for (genvar p = 0; p < NENT; p++) begin : g_dot
      always_ff @(posedge clock) begin
         if (ce) begin
            s3_dot_ff[p] <= DOTW'(s2_px_ff[p]) + DOTW'(s2_py_ff[p]);
         end
      end
   end

   // Stage 4: magnitudes, signs, degenerate decision
   logic signed [DOTW-1:0] det_abs;
   logic [MAGW-1:0]        s4_adet_ff;
   logic [MAGW-1:0]        s4_mag_ff [NENT];
   logic                   s4_neg_ff [NENT];
   logic [SUW-1:0]         s4_sum_ff;
   logic                   s4_deg_ff;

   assign det_abs = s3_det_ff[DOTW-1] ? -s3_det_ff : s3_det_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s4_adet_ff <= det_abs[MAGW-1:0];
         s4_sum_ff  <= s3_sum_ff;
         s4_deg_ff  <= (s3_det_ff == '0) || (det_abs[MAGW-1:0] < MAGW'(det_thr_ff))
                       || s3_near_ff;
      end
   end

   for (genvar p = 0; p < NENT; p++) begin : g_mag
      logic signed [DOTW-1:0] dot_abs;
      assign dot_abs = s3_dot_ff[p][DOTW-1] ? -s3_dot_ff[p] : s3_dot_ff[p];
      always_ff @(posedge clock) begin
         if (ce) begin
            s4_mag_ff[p] <= dot_abs[MAGW-1:0];
            s4_neg_ff[p] <= s3_dot_ff[p][DOTW-1];
         end
      end
   end

   // Stage 5: denominator partial products, three times each magnitude
   logic [2*HALFW-1:0] s5_dlo_ff, s5_dhi_ff;
   logic [M3W-1:0]     s5_mag3_ff [NENT];
   logic               s5_neg_ff [NENT];
   logic               s5_deg_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s5_dlo_ff <= (2*HALFW)'(s4_adet_ff[HALFW-1:0]) * (2*HALFW)'(s4_sum_ff);
         s5_dhi_ff <= (2*HALFW)'(s4_adet_ff[MAGW-1:HALFW]) * (2*HALFW)'(s4_sum_ff);
         s5_deg_ff <= s4_deg_ff;
      end
   end

   // Stage 6: combine the denominator
   logic [DENW-1:0] s6_den_ff;
   logic [M3W-1:0]  s6_mag3_ff [NENT];
   logic            s6_neg_ff [NENT];
   logic            s6_deg_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s6_den_ff <= DENW'(s5_dlo_ff) + (DENW'(s5_dhi_ff) << HALFW);
         s6_deg_ff <= s5_deg_ff;
      end
   end

   // Stage 7: rounding numerators and doubled divisor
   logic [NW-1:0]  s7_num_ff [NENT];
   logic [D2W-1:0] s7_d2_ff;
   logic           s7_neg_ff [NENT];
   logic           s7_deg_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s7_d2_ff  <= {s6_den_ff, 1'b0};
         s7_deg_ff <= s6_deg_ff;
      end
   end

   for (genvar p = 0; p < NENT; p++) begin : g_prep
      always_ff @(posedge clock) begin
         if (ce) begin
            s5_mag3_ff[p] <= M3W'({s4_mag_ff[p], 1'b0}) + M3W'(s4_mag_ff[p]);
            s5_neg_ff[p]  <= s4_neg_ff[p];
            s6_mag3_ff[p] <= s5_mag3_ff[p];
            s6_neg_ff[p]  <= s5_neg_ff[p];
            s7_num_ff[p]  <= (NW'(s6_mag3_ff[p]) << NUM_SHIFT) + NW'(s6_den_ff);
            s7_neg_ff[p]  <= s6_neg_ff[p];
         end
      end
   end

   // Divider lanes: stage 0 checks saturation, then one quotient bit per stage
   logic [NW-1:0]  dv_rem_ff [DIVN+1][NENT];
   logic [QW-1:0]  dv_q_ff   [DIVN+1][NENT];
   logic           dv_ovf_ff [DIVN+1][NENT];
   logic           dv_neg_ff [DIVN+1][NENT];
   logic [D2W-1:0] dv_d2_ff  [DIVN+1];
   logic           dv_deg_ff [DIVN+1];

   always_ff @(posedge clock) begin
      if (ce) begin
         dv_d2_ff[0]  <= s7_d2_ff;
         dv_deg_ff[0] <= s7_deg_ff;
      end
   end

   for (genvar p = 0; p < NENT; p++) begin : g_ovf
      always_ff @(posedge clock) begin
         if (ce) begin
            dv_rem_ff[0][p] <= s7_num_ff[p];
            dv_q_ff[0][p]   <= '0;
            dv_ovf_ff[0][p] <= CMPW'(s7_num_ff[p]) >= (CMPW'(s7_d2_ff) << QW);
            dv_neg_ff[0][p] <= s7_neg_ff[p];
         end
      end
   end

   for (genvar j = 0; j < DIVN; j++) begin : g_div
      localparam int K = DIVN - 1 - j;
      logic [CMPW-1:0] dsh;
      assign dsh = CMPW'(dv_d2_ff[j]) << K;

      always_ff @(posedge clock) begin
         if (ce) begin
            dv_d2_ff[j+1]  <= dv_d2_ff[j];
            dv_deg_ff[j+1] <= dv_deg_ff[j];
         end
      end

      for (genvar p = 0; p < NENT; p++) begin : g_lane
         logic take;
         assign take = CMPW'(dv_rem_ff[j][p]) >= dsh;
         always_ff @(posedge clock) begin
            if (ce) begin
               dv_rem_ff[j+1][p] <= take ? dv_rem_ff[j][p] - dsh[NW-1:0] : dv_rem_ff[j][p];
               dv_q_ff[j+1][p]   <= take ? (dv_q_ff[j][p] | (QW'(1) << K)) : dv_q_ff[j][p];
               dv_ovf_ff[j+1][p] <= dv_ovf_ff[j][p];
               dv_neg_ff[j+1][p] <= dv_neg_ff[j][p];
            end
         end
      end
   end

   // Sign stage: saturate, apply sign, zero degenerate elements
   res_type res_ff;
   res_type res_in;

   always_comb begin
      res_in.deg = dv_deg_ff[DIVN];
      for (int p = 0; p < NENT; p++) begin
         if (dv_deg_ff[DIVN]) begin
            res_in.ent[p] = '0;
         end else if (dv_ovf_ff[DIVN][p]) begin
            res_in.ent[p] = dv_neg_ff[DIVN][p] ? ENT_MIN : ENT_MAX;
         end else if (dv_neg_ff[DIVN][p]) begin
            res_in.ent[p] = ENTW'(0) - {1'b0, dv_q_ff[DIVN][p]};
         end else begin
            res_in.ent[p] = {1'b0, dv_q_ff[DIVN][p]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         res_ff <= res_in;
      end
   end

   // Output register with skid: park a result when the output is held
   res_type out_ff;
   res_type skid_ff;
   logic    pop;

   assign pop = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || pop) begin
         out_ff <= skid_v_ff ? skid_ff : res_ff;
      end else if (push) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_entry_aa   = out_ff.ent[0];
   assign rsp_entry_ab   = out_ff.ent[1];
   assign rsp_entry_ac   = out_ff.ent[2];
   assign rsp_entry_bb   = out_ff.ent[3];
   assign rsp_entry_bc   = out_ff.ent[4];
   assign rsp_entry_cc   = out_ff.ent[5];
   assign rsp_degenerate = out_ff.deg;

   // A parked result always sits behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   // Degenerate elements carry all-zero entries
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_entry_aa == '0 && rsp_entry_ab == '0 &&
      rsp_entry_ac == '0 && rsp_entry_bb == '0 && rsp_entry_bc == '0 && rsp_entry_cc == '0))
      else $error("degenerate result with nonzero entry");

   // Diagonal entries come from squared norms and never go negative
   a_diag_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_entry_aa[ENTW-1] && !rsp_entry_bb[ENTW-1] && !rsp_entry_cc[ENTW-1]))
      else $error("negative diagonal stiffness entry");

endmodule

`default_nettype wire
